// ===== rtl/rphs_pkg.sv =====
package rphs_pkg;

    localparam int SLOTS     = 1024;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int BATCH_W   = 7;
    localparam int MAX_BATCH = 64;

    localparam logic [63:0] HASH_MUL  = 64'hc6a4a7935bd1e995;
    localparam int          HASH_SHR  = 47;
    localparam logic [63:0] HASH_SEED = 64'h8445d61a4e774912;
    localparam logic [63:0] HASH_INIT = HASH_SEED ^ (HASH_MUL << 3);

    localparam logic [1:0] MODE_INS  = 2'd0;
    localparam logic [1:0] MODE_REM  = 2'd1;
    localparam logic [1:0] MODE_SCAN = 2'd2;

    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_LIVE    = 2'd1;
    localparam logic [1:0] ST_DELETED = 2'd2;

    localparam logic [1:0] RES_OK        = 2'd0;
    localparam logic [1:0] RES_NOT_FOUND = 2'd1;
    localparam logic [1:0] RES_FULL      = 2'd2;
    localparam logic [1:0] RES_DUP       = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [31:0]       page_id;
        logic [SLOT_W-1:0] slot;
    } cmd_t;

endpackage

// ===== rtl/rphs_hash.sv =====
module rphs_hash (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          mode,
    input  logic [31:0]         page_id,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output rphs_pkg::cmd_t      cmd
);
    import rphs_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [1:0]  op_reg, op_next;
    logic [1:0]  ph_reg, ph_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] acc_reg, acc_next;
    cmd_t        cmd_reg, cmd_next;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] sum;
    logic [63:0] post;

    assign in_ready  = !busy_reg && !done_reg;
    assign cmd_valid = done_reg;
    assign cmd       = cmd_reg;

    assign mul_a = (ph_reg == 2'd2) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b = (ph_reg == 2'd1) ? HASH_MUL[63:32] : HASH_MUL[31:0];
    assign prod  = {32'd0, mul_a} * {32'd0, mul_b};
    assign sum   = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};

    always_comb
    begin
        unique case (op_reg)
            2'd1:    post = sum ^ HASH_INIT;
            default: post = sum ^ (sum >> HASH_SHR);
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        op_next   = op_reg;
        ph_next   = ph_reg;
        x_next    = x_reg;
        acc_next  = acc_reg;
        cmd_next  = cmd_reg;
        if (done_reg && cmd_ready)
        begin
            done_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            cmd_next.mode    = mode;
            cmd_next.page_id = page_id;
            cmd_next.slot    = '0;
            if (mode == MODE_INS || mode == MODE_REM)
            begin
                busy_next = 1'b1;
                x_next    = {32'd0, page_id};
                op_next   = 2'd0;
                ph_next   = 2'd0;
            end
            else
            begin
                done_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            unique case (ph_reg)
                2'd0:
                begin
                    acc_next = prod;
                    ph_next  = 2'd1;
                end
                2'd1:
                begin
                    acc_next = sum;
                    ph_next  = 2'd2;
                end
                default:
                begin
                    x_next  = post;
                    ph_next = 2'd0;
                    op_next = op_reg + 2'd1;
                    if (op_reg == 2'd3)
                    begin
                        busy_next     = 1'b0;
                        done_next     = 1'b1;
                        cmd_next.slot = post[SLOT_W-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= 2'd0;
            ph_reg   <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            ph_reg   <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        acc_reg <= acc_next;
        cmd_reg <= cmd_next;
    end

endmodule

// ===== rtl/rphs_fifo.sv =====
module rphs_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  rphs_pkg::cmd_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output rphs_pkg::cmd_t rd_data
);
    import rphs_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/rphs_engine.sv =====
module rphs_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  scan_batch_we,
    input  logic [6:0]            scan_batch,
    input  logic                  cmd_valid,
    output logic                  cmd_pop,
    input  rphs_pkg::cmd_t        cmd,
    output logic                  clearing,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic                  entry_valid,
    output logic [31:0]           scanned_page_id,
    output logic                  last
);
    import rphs_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EV   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [31:0] key_mem  [SLOTS];
    logic [1:0]  stat_mem [SLOTS];
    logic [31:0] key_q;
    logic [1:0]  stat_q;

    logic [2:0]         state_reg, state_next;
    logic [SLOT_W-1:0]  pos_reg, pos_next;
    logic [SLOT_W-1:0]  cnt_reg, cnt_next;
    logic [SLOT_W-1:0]  hand_reg, hand_next;
    logic [BATCH_W-1:0] batch_reg;
    logic [BATCH_W-1:0] rem_reg, rem_next;
    logic [1:0]         mode_reg, mode_next;
    logic [31:0]        pid_reg, pid_next;
    logic               pend_reg, pend_next;
    logic [31:0]        pend_key_reg, pend_key_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         status_reg;
    logic               entry_valid_reg, last_reg;
    logic [31:0]        id_reg;

    logic               out_free, emit;
    logic [1:0]         e_status;
    logic               e_valid, e_last;
    logic [31:0]        e_id;
    logic               key_we, stat_we;
    logic [1:0]         stat_wd;
    logic [BATCH_W-1:0] bsel;
    logic               hit;

    assign out_free        = !out_valid_reg || out_ready;
    assign clearing        = (state_reg == S_CLR);
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign entry_valid     = entry_valid_reg;
    assign scanned_page_id = id_reg;
    assign last            = last_reg;
    assign hit             = (stat_q == ST_LIVE) && (key_q == pid_reg);

    always_comb
    begin
        if (batch_reg == '0)
            bsel = BATCH_W'(1);
        else if (batch_reg > BATCH_W'(MAX_BATCH))
            bsel = BATCH_W'(MAX_BATCH);
        else
            bsel = batch_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        hand_next     = hand_reg;
        rem_next      = rem_reg;
        mode_next     = mode_reg;
        pid_next      = pid_reg;
        pend_next     = pend_reg;
        pend_key_next = pend_key_reg;
        cmd_pop       = 1'b0;
        emit          = 1'b0;
        e_status      = RES_OK;
        e_valid       = 1'b0;
        e_id          = '0;
        e_last        = 1'b1;
        key_we        = 1'b0;
        stat_we       = 1'b0;
        stat_wd       = ST_EMPTY;
        unique case (state_reg)
            S_CLR:
            begin
                stat_we  = 1'b1;
                pos_next = pos_reg + 1'b1;
                if (pos_reg == '1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    mode_next = cmd.mode;
                    pid_next  = cmd.page_id;
                    cnt_next  = '0;
                    if (cmd.mode == MODE_INS || cmd.mode == MODE_REM)
                    begin
                        cmd_pop    = 1'b1;
                        pos_next   = cmd.slot;
                        state_next = S_RD;
                    end
                    else if (cmd.mode == MODE_SCAN)
                    begin
                        cmd_pop    = 1'b1;
                        pos_next   = hand_reg;
                        hand_next  = hand_reg + SLOT_W'(bsel);
                        rem_next   = bsel;
                        pend_next  = 1'b0;
                        state_next = S_RD;
                    end
                    else if (out_free)
                    begin
                        cmd_pop = 1'b1;
                        emit    = 1'b1;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                if (mode_reg == MODE_INS)
                begin
                    if (stat_q != ST_LIVE)
                    begin
                        if (out_free)
                        begin
                            key_we     = 1'b1;
                            stat_we    = 1'b1;
                            stat_wd    = ST_LIVE;
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else if (hit)
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            e_status   = RES_DUP;
                            state_next = S_IDLE;
                        end
                    end
                    else if (cnt_reg == '1)
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            e_status   = RES_FULL;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else if (mode_reg == MODE_REM)
                begin
                    if (stat_q == ST_EMPTY || (!hit && cnt_reg == '1))
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            e_status   = RES_NOT_FOUND;
                            state_next = S_IDLE;
                        end
                    end
                    else if (hit)
                    begin
                        if (out_free)
                        begin
                            stat_we    = 1'b1;
                            stat_wd    = ST_DELETED;
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else if (!(stat_q == ST_LIVE && pend_reg && !out_free))
                begin
                    if (stat_q == ST_LIVE)
                    begin
                        if (pend_reg)
                        begin
                            emit    = 1'b1;
                            e_valid = 1'b1;
                            e_id    = pend_key_reg;
                            e_last  = 1'b0;
                        end
                        pend_next     = 1'b1;
                        pend_key_next = key_q;
                    end
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == BATCH_W'(1))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_valid    = pend_reg;
                    e_id       = pend_reg ? pend_key_reg : 32'd0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            pos_reg       <= '0;
            hand_reg      <= '0;
            batch_reg     <= BATCH_W'(MAX_BATCH);
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            hand_reg      <= hand_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (scan_batch_we)
                batch_reg <= scan_batch;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        mode_reg     <= mode_next;
        pid_reg      <= pid_next;
        pend_key_reg <= pend_key_next;
        if (emit)
        begin
            status_reg      <= e_status;
            entry_valid_reg <= e_valid;
            id_reg          <= e_id;
            last_reg        <= e_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[pos_reg] <= pid_reg;
        if (stat_we)
            stat_mem[pos_reg] <= stat_wd;
        key_q  <= key_mem[pos_reg];
        stat_q <= stat_mem[pos_reg];
    end

`ifndef NO_ASSERTIONS
    a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> !out_valid_reg && !cmd_pop)
        else $error("output or pop during clearing pass");
    a_scan_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && entry_valid_reg |-> status_reg == RES_OK)
        else $error("scan item with non-ok status");
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !entry_valid_reg |-> last_reg)
        else $error("non-scan item without last");
    a_write_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (key_we || (stat_we && state_reg != S_CLR)) |-> emit)
        else $error("table write without a result");
`endif

endmodule

// ===== rtl/resident_page_hash_set_top.sv =====
// Resident page hash set: open-addressed set of 32-bit page numbers, linear probing.
// Input channel (in_valid/in_ready, mode, page_id): insert, remove or clock scan.
// Output channel (out_valid/out_ready): status, entry_valid, scanned_page_id, last.
// Every item yields one result except a scan, which yields one per live slot swept
// (at least one); last marks the final result of the item.
// scan_batch_we/scan_batch sets slots swept per scan (0 acts as 1, above 64 as 64).
// Front: the hash runs four 64-bit multiplies (three 32x32 partial
// products each on one multiplier). A two-entry queue feeds the back end.
// Back: each probed or swept slot takes a registered table read, then an
// evaluate step, which waits on out_ready before it emits a result.
// After reset the status table is cleared one slot per cycle over all 1024 slots,
// during which in_ready stays low. When out_ready is low the back end stalls
// on its next result while the front keeps hashing until the queue is full.
module resident_page_hash_set_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [31:0] page_id,
    input  logic        scan_batch_we,
    input  logic [6:0]  scan_batch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        entry_valid,
    output logic [31:0] scanned_page_id,
    output logic        last
);
    import rphs_pkg::*;

    logic front_ready;
    logic clearing;
    logic f_valid, f_ready;
    cmd_t f_cmd;
    logic q_valid, q_pop;
    cmd_t q_cmd;

    assign in_ready = front_ready && !clearing;

    rphs_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid && !clearing),
        .in_ready  (front_ready),
        .mode      (mode),
        .page_id   (page_id),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    rphs_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_pop),
        .rd_data  (q_cmd)
    );

    rphs_engine u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .scan_batch_we   (scan_batch_we),
        .scan_batch      (scan_batch),
        .cmd_valid       (q_valid),
        .cmd_pop         (q_pop),
        .cmd             (q_cmd),
        .clearing        (clearing),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .entry_valid     (entry_valid),
        .scanned_page_id (scanned_page_id),
        .last            (last)
    );

endmodule
